/* hw/rtl/matrix_3x3_det_and_inverse_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 determinant and inverse unit
// Short forms for implication checks clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef MATRIX_3X3_DET_AND_INVERSE_UNIT_MACROS_SVH
`define MATRIX_3X3_DET_AND_INVERSE_UNIT_MACROS_SVH

// cons must hold in the same cycle as ante
`define M3DI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m3di: same-cycle check failed");

// cons must hold in the cycle after ante
`define M3DI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m3di: next-cycle check failed");

`endif

/* hw/rtl/m3di_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3di_pkg
// Types, widths and helpers shared by the 3x3 determinant and inverse unit.
// ----------------------------------------------------------------------------
package m3di_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DIM       = 3;
   localparam int NUM_LANES = DIM * DIM;
   localparam int ELEM_W    = 32;
   localparam int COF_W     = 2 * ELEM_W;            // 2x2 minor, exact
   localparam int DET_W     = ELEM_W + COF_W + 2;    // 3x3 determinant, exact
   localparam int QUO_W     = ELEM_W + 1;            // doubled quotient bits
   localparam int NUM2_W    = COF_W + 2 * FRAC_BITS + 1;
   localparam int REM_W     = DET_W + 1;
   localparam int CNT_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = CSR_IDX_W'(1);

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(3);
   localparam logic [CNT_W-1:0] DIM_FULL    = CNT_W'(3);
   localparam logic [CNT_W-1:0] DIM_TWO     = CNT_W'(2);

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic signed [DET_W-1:0]  det_type;

   localparam elem_type ONE_FIXED = ELEM_W'(64'd1 << FRAC_BITS);
   localparam elem_type SAT_MAX   = ELEM_W'(64'h7FFF_FFFF);
   localparam elem_type SAT_MIN   = ELEM_W'(64'h8000_0000);

   typedef enum logic [1:0] {
      SHAPE_3X3,
      SHAPE_2X2,
      SHAPE_OTHER
   } shape_type;

   typedef struct packed {
      elem_type elem_r0c0;
      elem_type elem_r0c1;
      elem_type elem_r0c2;
      elem_type elem_r1c0;
      elem_type elem_r1c1;
      elem_type elem_r1c2;
      elem_type elem_r2c0;
      elem_type elem_r2c1;
      elem_type elem_r2c2;
   } req_type;

   typedef struct packed {
      elem_type inv_r0c0;
      elem_type inv_r0c1;
      elem_type inv_r0c2;
      elem_type inv_r1c0;
      elem_type inv_r1c1;
      elem_type inv_r1c2;
      elem_type inv_r2c0;
      elem_type inv_r2c1;
      elem_type inv_r2c2;
      elem_type determinant;
      logic     singular;
   } rsp_type;

   typedef struct packed {
      elem_type determinant;
      logic     singular;
      logic     invertible;
   } det_res_type;

   // Saturate a sign/magnitude value; big flags magnitude bits above mag.
   function automatic elem_type sat_field(input logic neg, input logic big,
                                          input logic [QUO_W-1:0] mag);
      logic [QUO_W-1:0] lim;
      logic [QUO_W-1:0] neg_mag;
      elem_type         r;
      lim     = QUO_W'(1) << (ELEM_W - 1);
      neg_mag = QUO_W'(0) - mag;
      if (neg) begin
         if (big || (mag > lim)) r = SAT_MIN;
         else r = neg_mag[ELEM_W-1:0];
      end else begin
         if (big || (mag >= lim)) r = SAT_MAX;
         else r = mag[ELEM_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/m3di_cof_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3di_cof_lane
// One 2x2 minor a*d - b*c, two registered multiplies then a subtract.
// ----------------------------------------------------------------------------
module m3di_cof_lane (
   input  logic               clock,
   input  logic               en,
   input  m3di_pkg::elem_type a,
   input  m3di_pkg::elem_type b,
   input  m3di_pkg::elem_type c,
   input  m3di_pkg::elem_type d,
   output m3di_pkg::cof_type  cof
);
   import m3di_pkg::*;

   cof_type p1_ff;
   cof_type p2_ff;
   cof_type cof_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= a * d;
         p2_ff  <= b * c;
         // difference of two 32x32 products always fits 64 bits
         cof_ff <= p1_ff - p2_ff;
      end
   end

   assign cof = cof_ff;

endmodule

/* hw/rtl/m3di_det.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3di_det
// Expands the determinant along row 0, rounds and saturates it, and picks
// the determinant field for the configured shape.
// ----------------------------------------------------------------------------
module m3di_det (
   input  logic                   clock,
   input  logic                   en,
   input  m3di_pkg::elem_type     row0 [m3di_pkg::DIM],
   input  m3di_pkg::cof_type      cof [m3di_pkg::NUM_LANES],
   input  m3di_pkg::shape_type    shape,
   output logic [m3di_pkg::DET_W-1:0] dmag,
   output logic                   dneg,
   output m3di_pkg::det_res_type  res
);
   import m3di_pkg::*;

   localparam int PL_W  = 2 * ELEM_W + 1;
   localparam int R2_W  = COF_W + 1;
   localparam int R2S_W = R2_W - FRAC_BITS;
   localparam int R3_W  = DET_W + 1;
   localparam int R3S_W = R3_W - 2 * FRAC_BITS;

   // stage 1: partial products
   logic signed [PL_W-1:0]     pl_ff [DIM];
   logic signed [COF_W-1:0]    ph_ff [DIM];
   logic [COF_W-1:0]           m2_ff;
   logic                       m2neg_ff;
   shape_type                  shape1_ff;
   // stage 2
   det_type                    prod_ff [DIM];
   logic [R2_W-1:0]            r2_ff;
   logic                       neg2_ff;
   shape_type                  shape2_ff;
   // stage 3
   det_type                    det_ff;
   elem_type                   det2_3_ff;
   shape_type                  shape3_ff;
   // stage 4
   logic [DET_W-1:0]           dmag_ff;
   logic                       dneg_ff;
   logic                       dzero_ff;
   elem_type                   det2_4_ff;
   shape_type                  shape4_ff;
   // stage 5
   logic [R3_W-1:0]            r3_ff;
   logic                       dneg5_ff;
   logic                       dzero5_ff;
   elem_type                   det2_5_ff;
   shape_type                  shape5_ff;
   // stage 6
   det_res_type                res_ff;

   logic [R2S_W-1:0] sh2;
   elem_type         det2_in;
   logic [R3S_W-1:0] sh3;
   elem_type         det3;
   det_res_type      res_in;
   logic [DET_W-1:0] dmag_in;

   always_comb begin
      sh2     = r2_ff[R2_W-1:FRAC_BITS];
      det2_in = sat_field(neg2_ff, |sh2[R2S_W-1:QUO_W], sh2[QUO_W-1:0]);
      dmag_in = det_ff[DET_W-1] ? (DET_W'(0) - DET_W'(det_ff)) : DET_W'(det_ff);
      sh3     = r3_ff[R3_W-1:2*FRAC_BITS];
      det3    = sat_field(dneg5_ff, |sh3[R3S_W-1:QUO_W], sh3[QUO_W-1:0]);
      res_in  = '0;
      case (shape5_ff)
         SHAPE_3X3: begin
            res_in.determinant = dzero5_ff ? '0 : det3;
            res_in.singular    = dzero5_ff;
            res_in.invertible  = ~dzero5_ff;
         end
         SHAPE_2X2: begin
            res_in.determinant = det2_5_ff;
         end
         default: begin
            res_in.determinant = ONE_FIXED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIM; i++) begin
            pl_ff[i]   <= row0[i] * $signed({1'b0, cof[i][ELEM_W-1:0]});
            ph_ff[i]   <= row0[i] * $signed(cof[i][COF_W-1:ELEM_W]);
            prod_ff[i] <= (DET_W'(ph_ff[i]) <<< ELEM_W) + DET_W'(pl_ff[i]);
         end
         // the 2x2 determinant is the minor left over from the 3x3 corner
         m2neg_ff  <= cof[NUM_LANES-1][COF_W-1];
         m2_ff     <= cof[NUM_LANES-1][COF_W-1] ? (COF_W'(0) - COF_W'(cof[NUM_LANES-1]))
                                                 : COF_W'(cof[NUM_LANES-1]);
         shape1_ff <= shape;

         r2_ff     <= {1'b0, m2_ff} + (R2_W'(1) << (FRAC_BITS - 1));
         neg2_ff   <= m2neg_ff;
         shape2_ff <= shape1_ff;

         det_ff    <= prod_ff[0] + prod_ff[1] + prod_ff[2];
         det2_3_ff <= det2_in;
         shape3_ff <= shape2_ff;

         dmag_ff   <= dmag_in;
         dneg_ff   <= det_ff[DET_W-1];
         dzero_ff  <= (det_ff == '0);
         det2_4_ff <= det2_3_ff;
         shape4_ff <= shape3_ff;

         r3_ff     <= {1'b0, dmag_ff} + (R3_W'(1) << (2 * FRAC_BITS - 1));
         dneg5_ff  <= dneg_ff;
         dzero5_ff <= dzero_ff;
         det2_5_ff <= det2_4_ff;
         shape5_ff <= shape4_ff;

         res_ff    <= res_in;
      end
   end

   assign dmag = dmag_ff;
   assign dneg = dneg_ff;
   assign res  = res_ff;

endmodule

/* hw/rtl/m3di_div_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3di_div_lane
// One inverse entry: cofactor * 2^(2F) / |det|, rounded half away from zero
// and saturated. Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module m3di_div_lane (
   input  logic               clock,
   input  logic               en,
   input  m3di_pkg::cof_type  cof,
   input  logic               dneg,
   input  logic [m3di_pkg::DET_W-1:0] den_line [m3di_pkg::QUO_W+1],
   output m3di_pkg::elem_type inv
);
   import m3di_pkg::*;

   localparam int R0_W = NUM2_W - QUO_W;

   logic [COF_W-1:0]  cmag_ff;
   logic              cneg_ff;

   logic [REM_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  bits_ff [QUO_W];
   logic [QUO_W-1:0]  q_ff    [QUO_W+1];
   logic              neg_ff  [QUO_W+1];
   logic              ovf_ff  [QUO_W+1];
   elem_type          inv_ff;

   logic [NUM2_W-1:0] num2;
   logic [REM_W-1:0]  rem0;
   logic [REM_W-1:0]  rem_sh [QUO_W];
   logic              ge     [QUO_W];
   logic [REM_W-1:0]  rem_nx [QUO_W];
   logic [QUO_W:0]    qr;

   always_comb begin
      // doubled numerator; its top part must stay below den or we saturate
      num2 = {cmag_ff, {(2 * FRAC_BITS + 1){1'b0}}};
      rem0 = REM_W'(num2[NUM2_W-1:QUO_W]);
      for (int k = 0; k < QUO_W; k++) begin
         rem_sh[k] = {rem_ff[k][REM_W-2:0], bits_ff[k][QUO_W-1]};
         ge[k]     = rem_sh[k] >= {1'b0, den_line[k+1]};
         rem_nx[k] = ge[k] ? (rem_sh[k] - {1'b0, den_line[k+1]}) : rem_sh[k];
      end
      qr = ({1'b0, q_ff[QUO_W]} + (QUO_W + 1)'(1)) >> 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmag_ff    <= cof[COF_W-1] ? (COF_W'(0) - COF_W'(cof)) : COF_W'(cof);
         cneg_ff    <= cof[COF_W-1] ^ dneg;

         rem_ff[0]  <= rem0;
         bits_ff[0] <= num2[QUO_W-1:0];
         q_ff[0]    <= '0;
         neg_ff[0]  <= cneg_ff;
         ovf_ff[0]  <= rem0 >= {1'b0, den_line[0]};

         for (int k = 0; k < QUO_W; k++) begin
            if (k < QUO_W - 1) begin
               rem_ff[k+1]  <= rem_nx[k];
               bits_ff[k+1] <= bits_ff[k] << 1;
            end
            q_ff[k+1]   <= {q_ff[k][QUO_W-2:0], ge[k]};
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end

         // q_ff holds floor(2n/d); halving after +1 gives round half away
         inv_ff <= sat_field(neg_ff[QUO_W], ovf_ff[QUO_W], qr[QUO_W-1:0]);
      end
   end

   assign inv = inv_ff;

endmodule

/* hw/rtl/matrix_3x3_det_and_inverse_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_3x3_det_and_inverse_unit
// Determinant and adjugate-based inverse of a 3x3 signed Q16.16 matrix.
// ----------------------------------------------------------------------------
// Takes one matrix and returns one result per clock while rsp_ready is high.
// Each result passes 42 pipeline stages plus the output register; the length
// is set by the 33-stage restoring divider in each of the nine inverse
// lanes, one quotient bit per stage. A two-entry output buffer takes one
// more result while one waits; req_ready drops only when both entries are
// full. row_count and column_count select the shape: 3x3 gives determinant
// and inverse, 2x2 the top-left determinant only, anything else a
// determinant of one. Write them only while idle.
// ----------------------------------------------------------------------------
module matrix_3x3_det_and_inverse_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  m3di_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output m3di_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [m3di_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [m3di_pkg::CNT_W-1:0]       csr_wdata
);
   import m3di_pkg::*;

   localparam int LAST = QUO_W + 9;   // pipeline stages before the output slot

   logic [CNT_W-1:0] row_count_ff;
   logic [CNT_W-1:0] column_count_ff;

   logic             en;
   logic [LAST-1:0]  valid_ff;
   shape_type        shape_in;
   elem_type         elem [DIM][DIM];

   elem_type         row0_pipe_ff  [2][DIM];
   shape_type        shape_pipe_ff [2];
   cof_type          cof           [NUM_LANES];
   cof_type          cof_pipe_ff   [4][NUM_LANES];
   logic [DET_W-1:0] dmag;
   logic             dneg;
   logic [DET_W-1:0] den_pipe_ff   [QUO_W+1];
   det_res_type      det_res;
   det_res_type      res_pipe_ff   [QUO_W+1];
   elem_type         inv           [NUM_LANES];

   rsp_type          merged;
   det_res_type      fin;
   rsp_type          a_ff;
   rsp_type          b_ff;
   logic             a_valid_ff;
   logic             b_valid_ff;
   logic             a_valid_in;
   logic             b_valid_in;
   logic             load_a;
   logic             load_b;
   logic             a_from_b;
   logic             item;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= COUNT_RESET;
         column_count_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROW_COUNT:    row_count_ff    <= csr_wdata;
            CSR_COLUMN_COUNT: column_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (row_count_ff == DIM_FULL && column_count_ff == DIM_FULL) shape_in = SHAPE_3X3;
      else if (row_count_ff == DIM_TWO && column_count_ff == DIM_TWO) shape_in = SHAPE_2X2;
      else shape_in = SHAPE_OTHER;
   end

   // the whole pipeline holds only when the skid entry is occupied
   assign en        = ~b_valid_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= {valid_ff[LAST-2:0], req_valid};
   end

   always_comb begin
      elem[0][0] = req_data.elem_r0c0;
      elem[0][1] = req_data.elem_r0c1;
      elem[0][2] = req_data.elem_r0c2;
      elem[1][0] = req_data.elem_r1c0;
      elem[1][1] = req_data.elem_r1c1;
      elem[1][2] = req_data.elem_r1c2;
      elem[2][0] = req_data.elem_r2c0;
      elem[2][1] = req_data.elem_r2c1;
      elem[2][2] = req_data.elem_r2c2;
   end

   // cofactor lanes, lane i*3+j holds the cofactor of element (i, j)
   for (genvar gi = 0; gi < DIM; gi++) begin : g_row
      for (genvar gj = 0; gj < DIM; gj++) begin : g_col
         localparam int I1 = (gi + 1) % DIM;
         localparam int I2 = (gi + 2) % DIM;
         localparam int J1 = (gj + 1) % DIM;
         localparam int J2 = (gj + 2) % DIM;
         m3di_cof_lane u_cof (
            .clock (clock),
            .en    (en),
            .a     (elem[I1][J1]),
            .b     (elem[I1][J2]),
            .c     (elem[I2][J1]),
            .d     (elem[I2][J2]),
            .cof   (cof[gi*DIM+gj])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIM; i++) begin
            row0_pipe_ff[0][i] <= elem[0][i];
            row0_pipe_ff[1][i] <= row0_pipe_ff[0][i];
         end
         shape_pipe_ff[0] <= shape_in;
         shape_pipe_ff[1] <= shape_pipe_ff[0];
         for (int l = 0; l < NUM_LANES; l++) begin
            cof_pipe_ff[0][l] <= cof[l];
            for (int s = 1; s < 4; s++) cof_pipe_ff[s][l] <= cof_pipe_ff[s-1][l];
         end
         den_pipe_ff[0] <= dmag;
         res_pipe_ff[0] <= det_res;
         for (int s = 1; s <= QUO_W; s++) begin
            den_pipe_ff[s] <= den_pipe_ff[s-1];
            res_pipe_ff[s] <= res_pipe_ff[s-1];
         end
      end
   end

   m3di_det u_det (
      .clock (clock),
      .en    (en),
      .row0  (row0_pipe_ff[1]),
      .cof   (cof),
      .shape (shape_pipe_ff[1]),
      .dmag  (dmag),
      .dneg  (dneg),
      .res   (det_res)
   );

   for (genvar gl = 0; gl < NUM_LANES; gl++) begin : g_div
      m3di_div_lane u_div (
         .clock    (clock),
         .en       (en),
         .cof      (cof_pipe_ff[3][gl]),
         .dneg     (dneg),
         .den_line (den_pipe_ff),
         .inv      (inv[gl])
      );
   end

   // merge: inverse is the transposed cofactor array over det
   always_comb begin
      fin                  = res_pipe_ff[QUO_W];
      merged.inv_r0c0      = fin.invertible ? inv[0] : '0;
      merged.inv_r0c1      = fin.invertible ? inv[3] : '0;
      merged.inv_r0c2      = fin.invertible ? inv[6] : '0;
      merged.inv_r1c0      = fin.invertible ? inv[1] : '0;
      merged.inv_r1c1      = fin.invertible ? inv[4] : '0;
      merged.inv_r1c2      = fin.invertible ? inv[7] : '0;
      merged.inv_r2c0      = fin.invertible ? inv[2] : '0;
      merged.inv_r2c1      = fin.invertible ? inv[5] : '0;
      merged.inv_r2c2      = fin.invertible ? inv[8] : '0;
      merged.determinant   = fin.determinant;
      merged.singular      = fin.singular;
   end

   // output register plus skid entry
   assign item = en & valid_ff[LAST-1];

   always_comb begin
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      load_a     = 1'b0;
      load_b     = 1'b0;
      a_from_b   = 1'b0;
      if (b_valid_ff) begin
         if (rsp_ready) begin
            a_from_b   = 1'b1;
            b_valid_in = 1'b0;
         end
      end else begin
         if (a_valid_ff && rsp_ready) a_valid_in = 1'b0;
         if (item) begin
            if (!a_valid_ff || rsp_ready) begin
               load_a     = 1'b1;
               a_valid_in = 1'b1;
            end else begin
               load_b     = 1'b1;
               b_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) a_ff <= merged;
      else if (a_from_b) a_ff <= b_ff;
      if (load_b) b_ff <= merged;
   end

   assign rsp_valid = a_valid_ff;
   assign rsp_data  = a_ff;

endmodule

/* hw/rtl/m3di_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3di_checker
// Port-level checks for the 3x3 determinant and inverse unit.
// ----------------------------------------------------------------------------
`include "matrix_3x3_det_and_inverse_unit_macros.svh"

module m3di_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  m3di_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  m3di_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [m3di_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [m3di_pkg::CNT_W-1:0]       csr_wdata
);
   import m3di_pkg::*;

   logic unused_inputs;
   assign unused_inputs = req_valid ^ (^req_data) ^ csr_valid ^ csr_ready ^
                          (^csr_index) ^ (^csr_wdata);

   // a held result keeps its payload
   `M3DI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))

   // with no result pending the skid entry is empty, so requests flow
   `M3DI_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // backpressure on requests only follows a stalled result
   `M3DI_ASSERT_SAME(a_ready_fall, clock, reset, $fell(req_ready),
      $past(rsp_valid && !rsp_ready))

   // a singular matrix reports a zero determinant and zero diagonal inverse entries
   `M3DI_ASSERT_SAME(a_singular_zero, clock, reset, rsp_valid && rsp_data.singular,
      rsp_data.determinant == 0 && rsp_data.inv_r0c0 == 0 &&
      rsp_data.inv_r1c1 == 0 && rsp_data.inv_r2c2 == 0)

endmodule

bind matrix_3x3_det_and_inverse_unit m3di_checker u_m3di_checker (.*);

/* bench/m3di_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3di_result_checker
// Watches the request, response and register channels of the 3x3 unit,
// computes the determinant and inverse of each accepted matrix on the side
// and compares every response with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module m3di_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  m3di_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  m3di_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [m3di_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [m3di_pkg::CNT_W-1:0]     csr_wdata,
   output int                             outstanding,
   output int                             error_count,
   output int                             matrices_seen,
   output int                             singular_seen
);
   import m3di_pkg::*;

   typedef logic signed [159:0] wide_s;
   typedef logic [159:0]        wide_u;

   logic [CNT_W-1:0] rows_now;
   logic [CNT_W-1:0] cols_now;
   rsp_type          inverse_queue[$];

   // sign/magnitude to a saturated 32-bit field
   function automatic elem_type clamp_field(input logic neg, input wide_u mag);
      if (neg) begin
         if (mag > wide_u'(64'h8000_0000)) return SAT_MIN;
         return elem_type'(-mag);
      end
      if (mag >= wide_u'(64'h8000_0000)) return SAT_MAX;
      return elem_type'(mag);
   endfunction

   function automatic rsp_type predict_inverse(input req_type m,
                                               input logic [CNT_W-1:0] nr,
                                               input logic [CNT_W-1:0] nc);
      wide_s    e[3][3];
      wide_s    cof[3][3];
      wide_s    det;
      wide_s    d2;
      wide_u    dmag;
      wide_u    num;
      wide_u    q;
      wide_u    r;
      logic     dneg;
      logic     neg;
      elem_type inv[9];
      rsp_type  res;
      e[0][0] = m.elem_r0c0; e[0][1] = m.elem_r0c1; e[0][2] = m.elem_r0c2;
      e[1][0] = m.elem_r1c0; e[1][1] = m.elem_r1c1; e[1][2] = m.elem_r1c2;
      e[2][0] = m.elem_r2c0; e[2][1] = m.elem_r2c1; e[2][2] = m.elem_r2c2;
      res = '0;
      for (int k = 0; k < 9; k++) inv[k] = '0;
      if (nr == DIM_FULL && nc == DIM_FULL) begin
         det = '0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               cof[i][j] = e[(i+1)%3][(j+1)%3] * e[(i+2)%3][(j+2)%3]
                         - e[(i+1)%3][(j+2)%3] * e[(i+2)%3][(j+1)%3];
         for (int i = 0; i < 3; i++) det += e[0][i] * cof[0][i];
         if (det == 0) begin
            res.singular = 1'b1;
            return res;
         end
         dneg = det < 0;
         dmag = dneg ? wide_u'(-det) : wide_u'(det);
         res.determinant = clamp_field(dneg, (dmag + (wide_u'(1) << 31)) >> 32);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               num = (cof[i][j] < 0 ? wide_u'(-cof[i][j]) : wide_u'(cof[i][j])) << 32;
               q = num / dmag;
               r = num % dmag;
               if ((r << 1) >= dmag) q = q + 1;
               neg = (cof[i][j] < 0) != dneg;
               inv[j*3+i] = (q == 0) ? elem_type'(0) : clamp_field(neg, q);
            end
         {res.inv_r0c0, res.inv_r0c1, res.inv_r0c2, res.inv_r1c0, res.inv_r1c1,
          res.inv_r1c2, res.inv_r2c0, res.inv_r2c1, res.inv_r2c2} =
            {inv[0], inv[1], inv[2], inv[3], inv[4], inv[5], inv[6], inv[7], inv[8]};
      end else if (nr == DIM_TWO && nc == DIM_TWO) begin
         d2 = e[0][0] * e[1][1] - e[0][1] * e[1][0];
         dmag = d2 < 0 ? wide_u'(-d2) : wide_u'(d2);
         res.determinant = clamp_field(d2 < 0, (dmag + (wide_u'(1) << 15)) >> 16);
      end else begin
         res.determinant = ONE_FIXED;
      end
      return res;
   endfunction

   function automatic void report_field(input string name, input elem_type want,
                                        input elem_type got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t mismatch %s: expected %h, got %h", $realtime, name, want, got);
      end
   endfunction

   assign outstanding = inverse_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rows_now      <= COUNT_RESET;
         cols_now      <= COUNT_RESET;
         error_count   <= 0;
         matrices_seen <= 0;
         singular_seen <= 0;
         inverse_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROW_COUNT) rows_now <= csr_wdata;
            else if (csr_index == CSR_COLUMN_COUNT) cols_now <= csr_wdata;
         end
         if (req_valid && req_ready) begin
            inverse_queue.push_back(predict_inverse(req_data, rows_now, cols_now));
            matrices_seen <= matrices_seen + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (inverse_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("%0t response with nothing pending", $realtime);
            end else begin
               want = inverse_queue.pop_front();
               if (want.singular) singular_seen <= singular_seen + 1;
               report_field("inv_r0c0", want.inv_r0c0, rsp_data.inv_r0c0);
               report_field("inv_r0c1", want.inv_r0c1, rsp_data.inv_r0c1);
               report_field("inv_r0c2", want.inv_r0c2, rsp_data.inv_r0c2);
               report_field("inv_r1c0", want.inv_r1c0, rsp_data.inv_r1c0);
               report_field("inv_r1c1", want.inv_r1c1, rsp_data.inv_r1c1);
               report_field("inv_r1c2", want.inv_r1c2, rsp_data.inv_r1c2);
               report_field("inv_r2c0", want.inv_r2c0, rsp_data.inv_r2c0);
               report_field("inv_r2c1", want.inv_r2c1, rsp_data.inv_r2c1);
               report_field("inv_r2c2", want.inv_r2c2, rsp_data.inv_r2c2);
               report_field("determinant", want.determinant, rsp_data.determinant);
               report_field("singular", elem_type'(want.singular),
                            elem_type'(rsp_data.singular));
            end
         end
      end
   end

endmodule

/* bench/tb_matrix_3x3_det_and_inverse_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_3x3_det_and_inverse_unit
// Drives matrices and shape settings into the 3x3 determinant/inverse unit
// with random back-pressure; a side checker predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_matrix_3x3_det_and_inverse_unit;
   import m3di_pkg::*;

   localparam int ITEMS_PER_SHAPE = 60;
   localparam int NUM_SHAPES      = 10;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_wdata;
   int                   outstanding;
   int                   error_count;
   int                   matrices_seen;
   int                   singular_seen;
   int                   stall_mode;   // 0: light send/heavy drain, 1: reverse, 2: none

   logic [CNT_W-1:0] shape_rows[NUM_SHAPES] = '{3, 2, 1, 3, 0, 2, 3, 3, 1, 3};
   logic [CNT_W-1:0] shape_cols[NUM_SHAPES] = '{3, 2, 1, 1, 3, 2, 2, 3, 3, 3};

   matrix_3x3_det_and_inverse_unit DUT (.*);

   m3di_result_checker checker_inst (.*);

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_ready <= $urandom_range(99) >= 72;
         1: rsp_ready <= $urandom_range(99) >= 21;
         default: rsp_ready <= 1'b1;
      endcase
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d transactions pending", outstanding);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic elem_type pick_elem();
      case ($urandom_range(9))
         0, 1, 2: return elem_type'($urandom);
         3: return $urandom_range(1) ? SAT_MAX : SAT_MIN;
         4: return elem_type'($signed($urandom_range(15)) - 8);
         default: return elem_type'($signed($urandom_range(32'h80000)) - 32'sh40000);
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type m;
      m = {pick_elem(), pick_elem(), pick_elem(), pick_elem(), pick_elem(),
           pick_elem(), pick_elem(), pick_elem(), pick_elem()};
      // dependent rows make an exactly singular matrix
      if ($urandom_range(7) == 0) {m.elem_r2c0, m.elem_r2c1, m.elem_r2c2} =
                                  {m.elem_r0c0, m.elem_r0c1, m.elem_r0c2};
      return m;
   endfunction

   function automatic req_type diag_matrix(input elem_type a, input elem_type b,
                                           input elem_type c);
      req_type m;
      m = '0;
      m.elem_r0c0 = a; m.elem_r1c1 = b; m.elem_r2c2 = c;
      return m;
   endfunction

   // ready is looked at mid-cycle so the accepting edge is known before it comes
   task automatic send_matrix(input req_type m);
      int idle_pct;
      idle_pct = (stall_mode == 0) ? 21 : ((stall_mode == 1) ? 72 : 0);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      req_type m;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_ready  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      stall_mode = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset shape is 3x3
      send_matrix(diag_matrix(ONE_FIXED, ONE_FIXED, ONE_FIXED));
      send_matrix('0);
      send_matrix({9{SAT_MAX}});
      send_matrix({9{SAT_MIN}});
      send_matrix(diag_matrix(SAT_MIN, SAT_MAX, SAT_MIN));
      send_matrix(diag_matrix(elem_type'(1), elem_type'(1), elem_type'(1)));
      send_matrix(diag_matrix(elem_type'(-1), elem_type'(2), elem_type'(3)));
      send_matrix(diag_matrix(32'sh20000, -32'sh8000, 32'sh10000));
      send_matrix(diag_matrix(32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh7FFF_0000));
      m = diag_matrix(32'sh30000, 32'sh20000, -32'sh10000);
      m.elem_r0c2 = 32'sh18000; m.elem_r2c0 = -32'sh4000; m.elem_r1c0 = 32'sh1;
      send_matrix(m);
      m = {32'sh10000, 32'sh20000, 32'sh30000, 32'sh20000, 32'sh40000, 32'sh60000,
           32'sh7, -32'sh3, 32'sh5};
      send_matrix(m);
      send_matrix({SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN,
                   SAT_MAX, SAT_MIN, SAT_MAX});
      send_matrix({9{32'sh5555_5555}});
      send_matrix({32'shAAAA_AAAA, 32'sh5555_5555, 32'sh0, 32'sh5555_5555,
                   32'shAAAA_AAAA, 32'sh0, 32'sh0, 32'sh0, 32'sh1});
      drain();

      // out-of-range register indexes must be ignored
      write_reg(CSR_IDX_W'(2), CNT_W'(1));
      write_reg(CSR_IDX_W'(3), CNT_W'(2));

      for (int s = 0; s < NUM_SHAPES; s++) begin
         stall_mode = (s * 3) / NUM_SHAPES;
         write_reg(CSR_ROW_COUNT, shape_rows[s]);
         write_reg(CSR_COLUMN_COUNT, shape_cols[s]);
         csr_valid <= 1'b0;
         if (s == 1) begin
            send_matrix({SAT_MIN, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX,
                         SAT_MAX, SAT_MAX, SAT_MAX});
            send_matrix({SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MIN,
                         SAT_MIN, SAT_MIN, SAT_MIN});
         end
         for (int n = 0; n < ITEMS_PER_SHAPE; n++) send_matrix(random_matrix());
         drain();
      end

      $display("covered %0d matrices over %0d shape settings, %0d singular",
               matrices_seen, NUM_SHAPES + 1, singular_seen);
      $display("stall profiles: light/heavy, heavy/light, none");
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/m3di_pkg.sv
hw/rtl/m3di_cof_lane.sv
hw/rtl/m3di_det.sv
hw/rtl/m3di_div_lane.sv
hw/rtl/matrix_3x3_det_and_inverse_unit.sv
hw/rtl/m3di_checker.sv
bench/m3di_result_checker.sv
bench/tb_matrix_3x3_det_and_inverse_unit.sv
